// ===== src/sxfb_pkg.sv =====
package sxfb_pkg;

  // item function codes
  typedef enum logic {
    FUNC_CLEAR = 1'b0,
    FUNC_DRAW  = 1'b1
  } func_e;

  // fixed field widths
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned ROW_IDX_W   = 4;
  localparam int unsigned SPRITE_BITS = 8;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned PIX_W       = 64;

endpackage

// ===== src/sxfb_draw.sv =====
module sxfb_draw #(
  parameter int unsigned SCREEN_WIDTH = 64
) (
  input  logic [sxfb_pkg::COORD_W-1:0]     x_origin_i,
  input  logic [sxfb_pkg::SPRITE_BITS-1:0] sprite_row_i,
  input  logic [SCREEN_WIDTH-1:0]          row_old_i,
  output logic [SCREEN_WIDTH-1:0]          row_new_o,
  output logic                             hit_o
);
  import sxfb_pkg::*;

  localparam int unsigned WideW = SCREEN_WIDTH + SPRITE_BITS;

  logic [SPRITE_BITS-1:0] rev;
  logic [WideW-1:0]       wide;
  logic [SCREEN_WIDTH-1:0] mask;

  // sprite bit 7 is leftmost, so reverse to put it at the lowest column
  always_comb begin
    for (int k = 0; k < SPRITE_BITS; k++) begin
      rev[k] = sprite_row_i[SPRITE_BITS-1-k];
    end
  end

  // place the pixels at the origin, columns past the right edge drop off
  assign wide = {{SCREEN_WIDTH{1'b0}}, rev} << x_origin_i;
  assign mask = wide[SCREEN_WIDTH-1:0];

  // xor into the row, a lit pixel turned off is a collision
  assign row_new_o = row_old_i ^ mask;
  assign hit_o     = |(row_old_i & mask);

endmodule

// ===== src/sprite_xor_framebuffer.sv =====
// A result strobe comes for each taken item once it has passed the input register,
// then the result register.
// Throughput: one item per cycle; busy stays low, the row update is one
// read-modify-write of a row register between the two register stages.
// Reset clears every screen row and the collision flag at once; the receiver cannot stall.
module sprite_xor_framebuffer #(
  parameter int unsigned SCREEN_WIDTH  = 64,
  parameter int unsigned SCREEN_HEIGHT = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             func_i,
  input  logic [sxfb_pkg::COORD_W-1:0]     x_origin_i,
  input  logic [sxfb_pkg::COORD_W-1:0]     y_origin_i,
  input  logic [sxfb_pkg::ROW_IDX_W-1:0]   row_index_i,
  input  logic [sxfb_pkg::SPRITE_BITS-1:0] sprite_row_i,
  output logic                             done_o,
  output logic                             collision_o,
  output logic [sxfb_pkg::ADDR_W-1:0]      row_address_o,
  output logic [sxfb_pkg::PIX_W-1:0]       row_pixels_o,
  output logic                             row_visible_o
);
  import sxfb_pkg::*;

  localparam int unsigned RowAw = $clog2(SCREEN_HEIGHT);
  localparam int unsigned DyW   = COORD_W + 1;

  // input register
  logic                   in_vld_q;
  logic                   func_q;
  logic [COORD_W-1:0]     x_q, y_q;
  logic [ROW_IDX_W-1:0]   ri_q;
  logic [SPRITE_BITS-1:0] spr_q;

  // screen and flag
  logic [SCREEN_WIDTH-1:0] rows_q [SCREEN_HEIGHT];
  logic                    coll_q, coll_d;

  // result register
  logic              out_vld_q;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [PIX_W-1:0]  pix_q, pix_d;
  logic              vis_q, vis_d;

  logic [DyW-1:0]          dy;
  logic                    on_screen;
  logic [RowAw-1:0]        row_sel;
  logic [SCREEN_WIDTH-1:0] row_old, row_new;
  logic                    hit;
  logic                    is_draw;

  // an item can enter every cycle
  assign busy = 1'b0;

  // capture the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q <= func_i;
      x_q    <= x_origin_i;
      y_q    <= y_origin_i;
      ri_q   <= row_index_i;
      spr_q  <= sprite_row_i;
    end
  end

  // target row
  assign is_draw   = (func_q == FUNC_DRAW);
  assign dy        = DyW'(y_q) + DyW'(ri_q);
  assign on_screen = (dy < DyW'(SCREEN_HEIGHT));
  assign row_sel   = dy[RowAw-1:0];
  assign row_old   = on_screen ? rows_q[row_sel] : '0;

  sxfb_draw #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_draw (
    .x_origin_i  (x_q),
    .sprite_row_i(spr_q),
    .row_old_i   (row_old),
    .row_new_o   (row_new),
    .hit_o       (hit)
  );

  // collision flag: row zero starts a sprite, an erased pixel sets it
  always_comb begin
    coll_d = coll_q;
    if (in_vld_q && is_draw) begin
      if (ri_q == '0) begin
        coll_d = 1'b0;
      end
      if (on_screen && hit) begin
        coll_d = 1'b1;
      end
    end
  end

  // result fields
  always_comb begin
    addr_d = '0;
    pix_d  = '0;
    vis_d  = 1'b0;
    if (is_draw && on_screen) begin
      addr_d = dy[ADDR_W-1:0];
      pix_d  = PIX_W'(row_new);
      vis_d  = 1'b1;
    end
  end

  // screen rows: clear all or write back the drawn row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < SCREEN_HEIGHT; r++) begin
        rows_q[r] <= '0;
      end
      coll_q <= 1'b0;
    end else begin
      coll_q <= coll_d;
      if (in_vld_q) begin
        if (!is_draw) begin
          for (int r = 0; r < SCREEN_HEIGHT; r++) begin
            rows_q[r] <= '0;
          end
        end else if (on_screen) begin
          rows_q[row_sel] <= row_new;
        end
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      addr_q <= addr_d;
      pix_q  <= pix_d;
      vis_q  <= vis_d;
    end
  end

  assign done_o        = out_vld_q;
  assign collision_o   = coll_q;
  assign row_address_o = addr_q;
  assign row_pixels_o  = pix_q;
  assign row_visible_o = vis_q;

endmodule

// ===== src/sxfb_checker.sv =====
module sxfb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             func_i,
  input logic [sxfb_pkg::ROW_IDX_W-1:0]   row_index_i,
  input logic [sxfb_pkg::SPRITE_BITS-1:0] sprite_row_i,
  input logic                             done_o,
  input logic                             collision_o,
  input logic [sxfb_pkg::ADDR_W-1:0]      row_address_o,
  input logic [sxfb_pkg::PIX_W-1:0]       row_pixels_o,
  input logic                             row_visible_o
);
  import sxfb_pkg::*;

  // every taken item gives its strobe through the input and result registers
  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 done_o)
    else $error("taken item produced no result");

  // no strobe without a matching item taken earlier
  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without an item");

  // a row that was not written reports zeros
  a_hidden_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !row_visible_o |-> row_address_o == '0 && row_pixels_o == '0)
    else $error("hidden row carries data");

  // a clear item never reports a visible row
  a_clear_not_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(func_i == FUNC_CLEAR, 2) |-> !row_visible_o)
    else $error("clear item reported a visible row");

  // an empty first sprite row leaves the flag cleared
  a_empty_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(func_i == FUNC_DRAW && row_index_i == '0 && sprite_row_i == '0, 2)
    |-> !collision_o)
    else $error("collision flag set by an empty first row");

endmodule

bind sprite_xor_framebuffer sxfb_checker u_sxfb_checker (.*);

// ===== tb/sprite_xor_framebuffer_test.sv =====
`timescale 1ns / 100ps

module sprite_xor_framebuffer_test;
  import sxfb_pkg::*;

  localparam int unsigned SCREEN_W     = 64;
  localparam int unsigned SCREEN_H     = 32;
  localparam int          TABLE_ROWS   = 16;
  localparam int          RANDOM_ITEMS = 1350;
  localparam int          IDLE_LIMIT   = 1000;
  localparam int          TAIL_CYCLES  = 4;

  // one sprite-row or clear item
  typedef struct packed {
    func_e                  func;
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
    logic [ROW_IDX_W-1:0]   row_idx;
    logic [SPRITE_BITS-1:0] sprite;
  } fb_item_t;

  // one row update coming back from the block
  typedef struct packed {
    logic              collision;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixels;
    logic              visible;
  } row_update_t;

  // directed stimulus row, with a hand-written result where it is obvious
  typedef struct packed {
    fb_item_t    item;
    logic        typed;
    row_update_t res;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic                   func_i;
  logic [COORD_W-1:0]     x_origin_i;
  logic [COORD_W-1:0]     y_origin_i;
  logic [ROW_IDX_W-1:0]   row_index_i;
  logic [SPRITE_BITS-1:0] sprite_row_i;
  logic                   done_o;
  logic                   collision_o;
  logic [ADDR_W-1:0]      row_address_o;
  logic [PIX_W-1:0]       row_pixels_o;
  logic                   row_visible_o;

  logic [PIX_W-1:0] screen_model [SCREEN_H];
  logic             collision_model;
  row_update_t      pending_rows [$];
  dir_row_t         dir_tab [TABLE_ROWS];
  int               items_sent;
  int               errors;
  int               idle_cycles;

  sprite_xor_framebuffer #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .x_origin_i   (x_origin_i),
    .y_origin_i   (y_origin_i),
    .row_index_i  (row_index_i),
    .sprite_row_i (sprite_row_i),
    .done_o       (done_o),
    .collision_o  (collision_o),
    .row_address_o(row_address_o),
    .row_pixels_o (row_pixels_o),
    .row_visible_o(row_visible_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // screen model: xor one sprite row in, or wipe the screen
  function automatic row_update_t apply_sprite_row(input fb_item_t it);
    row_update_t      r;
    logic [PIX_W-1:0] mask;
    int unsigned      col;
    int unsigned      dy;
    int               k;
    r    = '0;
    mask = '0;
    if (it.func == FUNC_CLEAR) begin
      for (k = 0; k < SCREEN_H; k++) screen_model[k] = '0;
      r.collision = collision_model;
      return r;
    end
    if (it.row_idx == '0) collision_model = 1'b0;
    dy = it.y + it.row_idx;
    // row below the bottom edge: nothing written
    if (dy >= SCREEN_H) begin
      r.collision = collision_model;
      return r;
    end
    // bit 7 is leftmost, columns past the right edge are clipped
    for (k = 0; k < SPRITE_BITS; k++) begin
      col = it.x + k;
      if (it.sprite[SPRITE_BITS-1-k] && col < SCREEN_W) mask[col] = 1'b1;
    end
    if ((screen_model[dy] & mask) != '0) collision_model = 1'b1;
    screen_model[dy] = screen_model[dy] ^ mask;
    r.collision = collision_model;
    r.addr      = dy[ADDR_W-1:0];
    r.pixels    = screen_model[dy];
    r.visible   = 1'b1;
    return r;
  endfunction

  function automatic int pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // drive one item at the falling edge and hold it until taken
  task automatic send_item(input fb_item_t it, input int gap, input bit typed,
                           input row_update_t typed_res);
    row_update_t r;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start        <= 1'b1;
    func_i       <= it.func;
    x_origin_i   <= it.x;
    y_origin_i   <= it.y;
    row_index_i  <= it.row_idx;
    sprite_row_i <= it.sprite;
    do @(posedge clk_i); while (busy);
    r = apply_sprite_row(it);
    pending_rows.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // hold off until every pending row update has come back
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
  endtask

  // compare each row update with the oldest pending one
  always @(posedge clk_i) begin : check_rows
    row_update_t want;
    if (rst_ni && done_o) begin
      if (pending_rows.size() == 0) begin
        $display("%0t unexpected row update: addr %h pixels %h", $time,
                 row_address_o, row_pixels_o);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        if (collision_o !== want.collision) begin
          $display("%0t collision: expected %h actual %h", $time, want.collision,
                   collision_o);
          errors++;
        end
        if (row_address_o !== want.addr) begin
          $display("%0t row_address: expected %h actual %h", $time, want.addr,
                   row_address_o);
          errors++;
        end
        if (row_pixels_o !== want.pixels) begin
          $display("%0t row_pixels: expected %h actual %h", $time, want.pixels,
                   row_pixels_o);
          errors++;
        end
        if (row_visible_o !== want.visible) begin
          $display("%0t row_visible: expected %h actual %h", $time, want.visible,
                   row_visible_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    fb_item_t                it;
    logic [SPRITE_BITS-1:0]  rows [16];
    logic [COORD_W-1:0]      sx;
    logic [COORD_W-1:0]      sy;
    int                      n;
    int                      kind;
    int                      pass;
    bit                      calm;
    rst_ni          = 1'b0;
    start           = 1'b0;
    func_i          = 1'b0;
    x_origin_i      = '0;
    y_origin_i      = '0;
    row_index_i     = '0;
    sprite_row_i    = '0;
    items_sent      = 0;
    errors          = 0;
    collision_model = 1'b0;
    for (int k = 0; k < SCREEN_H; k++) screen_model[k] = '0;

    // directed table: lit row, erase with collision, clear keeps flag,
    // far right origin, far bottom origin, right edge clipping, bottom edge
    dir_tab[0]  = '{'{FUNC_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF}, 1'b1,
                    '{1'b0, 5'd0, 64'h0000_0000_0000_00FF, 1'b1}};
    dir_tab[1]  = '{'{FUNC_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF}, 1'b1,
                    '{1'b1, 5'd0, 64'h0, 1'b1}};
    dir_tab[2]  = '{'{FUNC_CLEAR, 8'd0, 8'd0, 4'd0, 8'h00}, 1'b1,
                    '{1'b1, 5'd0, 64'h0, 1'b0}};
    dir_tab[3]  = '{'{FUNC_DRAW, 8'd255, 8'd0, 4'd0, 8'hFF}, 1'b1,
                    '{1'b0, 5'd0, 64'h0, 1'b1}};
    dir_tab[4]  = '{'{FUNC_DRAW, 8'd0, 8'd255, 4'd15, 8'hFF}, 1'b1,
                    '{1'b0, 5'd0, 64'h0, 1'b0}};
    dir_tab[5]  = '{'{FUNC_DRAW, 8'd56, 8'd31, 4'd0, 8'h81}, 1'b1,
                    '{1'b0, 5'd31, 64'h8100_0000_0000_0000, 1'b1}};
    dir_tab[6]  = '{'{FUNC_DRAW, 8'd60, 8'd30, 4'd1, 8'hFF}, 1'b1,
                    '{1'b1, 5'd31, 64'h7100_0000_0000_0000, 1'b1}};
    dir_tab[7]  = '{'{FUNC_DRAW, 8'd10, 8'd17, 4'd15, 8'hAA}, 1'b0, '0};
    dir_tab[8]  = '{'{FUNC_DRAW, 8'd0, 8'd16, 4'd15, 8'h55}, 1'b0, '0};
    dir_tab[9]  = '{'{FUNC_DRAW, 8'd7, 8'd5, 4'd3, 8'h01}, 1'b0, '0};
    dir_tab[10] = '{'{FUNC_DRAW, 8'd63, 8'd0, 4'd0, 8'h80}, 1'b0, '0};
    dir_tab[11] = '{'{FUNC_DRAW, 8'd64, 8'd1, 4'd0, 8'hFF}, 1'b0, '0};
    dir_tab[12] = '{'{FUNC_DRAW, 8'd128, 8'd128, 4'd0, 8'h00}, 1'b0, '0};
    dir_tab[13] = '{'{FUNC_DRAW, 8'd0, 8'd0, 4'd0, 8'h00}, 1'b0, '0};
    dir_tab[14] = '{'{FUNC_DRAW, 8'h5A, 8'hA5, 4'hA, 8'h5A}, 1'b0, '0};
    dir_tab[15] = '{'{FUNC_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF}, 1'b0, '0};

    // reset
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    for (int i = 0; i < TABLE_ROWS; i++)
      send_item(dir_tab[i].item, pick_gap(i < 8), dir_tab[i].typed, dir_tab[i].res);
    wait_drained();

    // random part: mostly whole sprites, some clears and loose items
    while (items_sent < TABLE_ROWS + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      calm = ($urandom_range(0, 3) == 0);
      if (kind < 4) begin
        it.func    = FUNC_CLEAR;
        it.x       = COORD_W'($urandom_range(0, 255));
        it.y       = COORD_W'($urandom_range(0, 255));
        it.row_idx = ROW_IDX_W'($urandom_range(0, 15));
        it.sprite  = SPRITE_BITS'($urandom_range(0, 255));
        send_item(it, pick_gap(calm), 1'b0, '0);
      end else if (kind < 16) begin
        it.func    = func_e'($urandom_range(0, 1));
        it.x       = COORD_W'($urandom_range(0, 255));
        it.y       = COORD_W'($urandom_range(0, 255));
        it.row_idx = ROW_IDX_W'($urandom_range(0, 15));
        it.sprite  = SPRITE_BITS'($urandom_range(0, 255));
        send_item(it, pick_gap(calm), 1'b0, '0);
      end else begin
        sx = ($urandom_range(0, 9) < 7) ? COORD_W'($urandom_range(0, 63))
                                        : COORD_W'($urandom_range(0, 255));
        sy = ($urandom_range(0, 9) < 7) ? COORD_W'($urandom_range(0, 31))
                                        : COORD_W'($urandom_range(0, 255));
        n  = $urandom_range(1, 15);
        for (int r = 0; r < n; r++) rows[r] = SPRITE_BITS'($urandom_range(0, 255));
        // a second pass of the same sprite erases it and collides if it left any pixel lit
        pass = ($urandom_range(0, 2) == 0) ? 2 : 1;
        for (int p = 0; p < pass; p++) begin
          for (int r = 0; r < n; r++) begin
            it.func    = FUNC_DRAW;
            it.x       = sx;
            it.y       = sy;
            it.row_idx = ROW_IDX_W'(r);
            it.sprite  = rows[r];
            send_item(it, pick_gap(calm), 1'b0, '0);
          end
        end
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
    end

    // drain and wrap up
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
